// ===== src/sbpp_pkg.sv =====
// Shared constants and types for the spectral band peak picker.
package sbpp_pkg;

	localparam int MAG_BITS   = 32;
	localparam int NUM_BANDS  = 6;
	localparam int FRAME_BINS = 513;
	localparam int BIN_W      = 10;
	localparam int BAND_W     = 3;
	localparam int MAG_PORT_W = 32;
	localparam int SUM_W      = MAG_BITS + 3;

	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(FRAME_BINS - 1);

	localparam logic [BIN_W-1:0] BAND_START [NUM_BANDS] = '{
		BIN_W'(0), BIN_W'(10), BIN_W'(20), BIN_W'(40), BIN_W'(80), BIN_W'(160)
	};

	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [BIN_W-1:0]    bin_t;
	typedef logic [NUM_BANDS-1:0] band_mask_t;

endpackage

// ===== src/spectral_band_peak_picker_core.sv =====
// Top level: per-band peak tracking and frame-end peak selection.
// Input: one bin per cycle, no stall except a frame end arriving while the
//   previous frame's results are still draining.
// Frame end: end_s1, end_s2 (snapshot), pend_q; results (up to 6 per frame) then
//   leave one per cycle unless out_ready stalls, through one output register.
// Reset (arst_n low, async): bin counter, peaks, out_valid, stage flags cleared.
module spectral_band_peak_picker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] magnitude,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  peak_bin,
	output logic [31:0] peak_magnitude,
	output logic        peak_valid,
	output logic        frame_last
);

	sbpp_pkg::bin_t                 bin_q;
	sbpp_pkg::mag_t                 pk_val_q [sbpp_pkg::NUM_BANDS];
	sbpp_pkg::bin_t                 pk_idx_q [sbpp_pkg::NUM_BANDS];
	sbpp_pkg::mag_t                 snap_val_s2 [sbpp_pkg::NUM_BANDS];
	sbpp_pkg::bin_t                 snap_idx_s2 [sbpp_pkg::NUM_BANDS];
	logic [sbpp_pkg::SUM_W-1:0]     sum_s2;
	logic [sbpp_pkg::SUM_W-1:0]     sum_c;
	logic                           end_s1;
	logic                           end_s2;
	sbpp_pkg::band_mask_t           pend_q;
	sbpp_pkg::band_mask_t           qual_c;
	sbpp_pkg::band_mask_t           pend_rest_c;
	logic                           marker_q;
	logic [sbpp_pkg::BAND_W-1:0]    band_c;
	logic [sbpp_pkg::BAND_W-1:0]    pick_c;
	logic                           band_first_c;
	logic                           busy_c;
	logic                           accept_c;
	logic                           load_c;
	sbpp_pkg::mag_t                 mag_c;
	logic                           out_valid_q;
	sbpp_pkg::bin_t                 out_bin_q;
	sbpp_pkg::mag_t                 out_mag_q;
	logic                           out_pv_q;
	logic                           out_last_q;

	assign mag_c    = sbpp_pkg::mag_t'(magnitude);
	assign busy_c   = end_s1 | end_s2 | (pend_q != '0) | marker_q;
	assign in_ready = !((bin_q == sbpp_pkg::LAST_BIN) && busy_c);
	assign accept_c = in_valid & in_ready;

	always_comb begin
		band_c = '0;
		for (int k = 1; k < sbpp_pkg::NUM_BANDS; k++) begin
			if (bin_q >= sbpp_pkg::BAND_START[k]) begin
				band_c = sbpp_pkg::BAND_W'(k);
			end
		end
		band_first_c = (bin_q == sbpp_pkg::BAND_START[band_c]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			for (int k = 0; k < sbpp_pkg::NUM_BANDS; k++) begin
				pk_val_q[k] <= '0;
				pk_idx_q[k] <= '0;
			end
		end else if (accept_c) begin
			if (bin_q == sbpp_pkg::LAST_BIN) begin
				bin_q <= '0;
			end else begin
				bin_q <= bin_q + sbpp_pkg::BIN_W'(1);
			end
			for (int k = 0; k < sbpp_pkg::NUM_BANDS; k++) begin
				if (band_c == sbpp_pkg::BAND_W'(k) && (band_first_c || mag_c > pk_val_q[k])) begin
					pk_val_q[k] <= mag_c;
					pk_idx_q[k] <= bin_q;
				end
			end
		end
	end

	// Frame-end pipeline: snapshot and sum, then threshold test.
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < sbpp_pkg::NUM_BANDS; k++) begin
			sum_c = sum_c + sbpp_pkg::SUM_W'(pk_val_q[k]);
		end
	end

	always_comb begin
		for (int k = 0; k < sbpp_pkg::NUM_BANDS; k++) begin
			qual_c[k] = ((sbpp_pkg::SUM_W'(snap_val_s2[k]) << 2)
				+ sbpp_pkg::SUM_W'(snap_val_s2[k])) > sum_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_s1 <= 1'b0;
			end_s2 <= 1'b0;
		end else begin
			end_s1 <= accept_c && (bin_q == sbpp_pkg::LAST_BIN);
			end_s2 <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (end_s1) begin
			sum_s2 <= sum_c;
			for (int k = 0; k < sbpp_pkg::NUM_BANDS; k++) begin
				snap_val_s2[k] <= pk_val_q[k];
				snap_idx_s2[k] <= pk_idx_q[k];
			end
		end
	end

	// Result emission: lowest pending band first.
	always_comb begin
		pick_c = '0;
		for (int k = sbpp_pkg::NUM_BANDS - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				pick_c = sbpp_pkg::BAND_W'(k);
			end
		end
		pend_rest_c = pend_q;
		pend_rest_c[pick_c] = 1'b0;
	end

	assign load_c = ((pend_q != '0) || marker_q) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			marker_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (end_s2) begin
				pend_q   <= qual_c;
				marker_q <= (qual_c == '0);
			end else if (load_c) begin
				if (pend_q != '0) begin
					pend_q <= pend_rest_c;
				end else begin
					marker_q <= 1'b0;
				end
			end
			if (load_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			if (pend_q != '0) begin
				out_bin_q  <= snap_idx_s2[pick_c];
				out_mag_q  <= snap_val_s2[pick_c];
				out_pv_q   <= 1'b1;
				out_last_q <= (pend_rest_c == '0);
			end else begin
				out_bin_q  <= '0;
				out_mag_q  <= '0;
				out_pv_q   <= 1'b0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign peak_bin       = out_bin_q;
	assign peak_magnitude = sbpp_pkg::MAG_PORT_W'(out_mag_q);
	assign peak_valid     = out_pv_q;
	assign frame_last     = out_last_q;

endmodule

// ===== src/sbpp_checker.sv =====
// Port-level checker for the spectral band peak picker, with its bind.
module sbpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  peak_bin,
	input logic [31:0] peak_magnitude,
	input logic        peak_valid,
	input logic        frame_last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(peak_bin)
			&& $stable(peak_magnitude) && $stable(peak_valid) && $stable(frame_last))
		else $error("result changed while stalled");

	// empty-frame marker is always the whole frame
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !peak_valid |-> frame_last)
		else $error("marker without frame_last");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !peak_valid |-> peak_bin == 10'd0 && peak_magnitude == 32'd0)
		else $error("marker carries nonzero payload");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_bin <= 10'd512)
		else $error("peak_bin out of frame");

endmodule

bind spectral_band_peak_picker_core sbpp_checker u_sbpp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.peak_bin       (peak_bin),
	.peak_magnitude (peak_magnitude),
	.peak_valid     (peak_valid),
	.frame_last     (frame_last)
);
